// ===== src/rdrd_pkg.sv =====
package rdrd_pkg;

    localparam int LUMA_W     = 8;
    localparam int LEN_W      = 10;
    localparam int FRAC_W     = 16;
    localparam int FACTOR_W   = 16;
    localparam int CLUSTER_W  = 8;
    localparam int CNT_W      = 10;
    localparam int START_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_RAY_SAMPLES_DEF = 512;

    localparam logic [FRAC_W-1:0]    BASIC_RST   = 16'd3277;
    localparam logic [FRAC_W-1:0]    SLOPE_RST   = 16'd19661;
    localparam logic [FACTOR_W-1:0]  FACTOR_RST  = 16'd100;
    localparam logic [CLUSTER_W-1:0] CLUSTER_RST = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASIC,
        CFG_SLOPE,
        CFG_FACTOR,
        CFG_CLUSTER
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_UPD,
        ST_CHK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic upd;
        logic chk;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [LEN_W-1:0]  ray_length;
        logic [LUMA_W-1:0] frame_min_luma;
        logic [LUMA_W-1:0] frame_max_luma;
        logic              last_in_ray;
    } t_in_item;

endpackage

// ===== src/rdrd_if.sv =====
interface rdrd_in_if;
    import rdrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma;
    logic [LEN_W-1:0]  ray_length;
    logic [LUMA_W-1:0] frame_min_luma;
    logic [LUMA_W-1:0] frame_max_luma;
    logic              last_in_ray;

    modport source (output valid, luma, ray_length, frame_min_luma, frame_max_luma,
                    last_in_ray, input ready);
    modport sink   (input valid, luma, ray_length, frame_min_luma, frame_max_luma,
                    last_in_ray, output ready);
endinterface

interface rdrd_out_if;
    import rdrd_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] start_index;
    logic [CNT_W-1:0]   point_count;

    modport source (output valid, found, start_index, point_count, input ready);
    modport sink   (input valid, found, start_index, point_count, output ready);
endinterface

interface rdrd_cfg_if;
    import rdrd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ray_dark_run_detector.sv =====
// Dark-run detector for one radial scan ray. Samples arrive in ray order on i_in; the one
// marked last_in_ray produces a single beat on o_out (found, start_index, point_count) and
// clears the ray state, every other sample produces nothing. One sample is worked on at a
// time: each sample walks the steps (accept, two multiply steps for the threshold, run
// update, early-stop check, finish) of the sequencer; a sample after an early stop or
// beyond MAX_RAY_SAMPLES goes from accept straight to finish. A last sample waits in the
// finish step while the previous result still sits unread in the output register.
// Configuration beats on i_cfg are taken at any time but belong between rays.
module ray_dark_run_detector #(
    parameter int MAX_RAY_SAMPLES = rdrd_pkg::MAX_RAY_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdrd_in_if.sink    i_in,
    rdrd_cfg_if.sink   i_cfg,
    rdrd_out_if.source o_out
);
    import rdrd_pkg::*;

    t_cmd     w_cmd;
    t_status  w_sts;
    t_in_item w_item;
    logic     w_ready;

    assign i_in.ready = w_ready;

    assign w_item.luma           = i_in.luma;
    assign w_item.ray_length     = i_in.ray_length;
    assign w_item.frame_min_luma = i_in.frame_min_luma;
    assign w_item.frame_max_luma = i_in.frame_max_luma;
    assign w_item.last_in_ray    = i_in.last_in_ray;

    rdrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rdrd_datapath #(
        .MAX_RAY_SAMPLES (MAX_RAY_SAMPLES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_item  (w_item),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== src/rdrd_ctrl.sv =====
module rdrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rdrd_pkg::t_status i_sts,
    output rdrd_pkg::t_cmd    o_cmd
);
    import rdrd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    // stopped ray or index past the end: only the end-of-ray check remains
                    n_state = i_sts.skip ? ST_FIN : ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
                // otherwise hold until the output register frees
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_MUL1 || r_state == ST_FIN))
        else $error("accepted beat did not start a sample sequence");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!i_sts.out_busy && i_sts.last))
        else $error("result emitted into a busy output register");
    a_chk_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |=> (r_state == ST_FIN))
        else $error("check step not followed by finish step");
`endif

endmodule

// ===== src/rdrd_datapath.sv =====
module rdrd_datapath #(
    parameter int MAX_RAY_SAMPLES = rdrd_pkg::MAX_RAY_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdrd_pkg::t_cmd     i_cmd,
    output rdrd_pkg::t_status  o_sts,
    input  rdrd_pkg::t_in_item i_item,
    rdrd_cfg_if.sink           i_cfg,
    rdrd_out_if.source         o_out
);
    import rdrd_pkg::*;

    localparam int IW     = $clog2(MAX_RAY_SAMPLES + 1);
    localparam int PA_W   = FRAC_W + LEN_W;
    localparam int PB_W   = FRAC_W + IW;
    localparam int SUM_W  = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int E_W    = LUMA_W + SUM_W;
    localparam int PC_W   = LUMA_W + LEN_W;
    localparam int LR_W   = PC_W + FRAC_W;
    localparam int CMP_W  = ((LR_W > E_W) ? LR_W : E_W) + 1;
    localparam int RS_W   = ((CNT_W + IW) > FACTOR_W) ? (CNT_W + IW) : FACTOR_W;
    localparam int DS_W   = ((2 * IW) > FACTOR_W) ? (2 * IW) : FACTOR_W;
    localparam int CD_W   = ((CLUSTER_W + IW) > CNT_W) ? (CLUSTER_W + IW) : CNT_W;
    localparam int DC_W   = (IW > CLUSTER_W) ? IW : CLUSTER_W;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

    // configuration
    logic [FRAC_W-1:0]    r_basic;
    logic [FRAC_W-1:0]    r_slope;
    logic [FACTOR_W-1:0]  r_factor;
    logic [CLUSTER_W-1:0] r_cluster;

    // current sample and threshold products
    t_in_item          r_item;
    logic [PA_W-1:0]   r_pa;
    logic [PB_W-1:0]   r_pb;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   r_pd;
    logic [E_W-1:0]    r_pe;
    logic              r_dark;

    // ray state
    logic [IW-1:0]     r_idx;
    logic [CNT_W-1:0]  r_run_count;
    logic [IW-1:0]     r_run_start;
    logic [CNT_W-1:0]  r_collected;
    logic              r_stopped;

    // output register
    logic               r_ovalid;
    logic               r_ofound;
    logic [START_W-1:0] r_ostart;
    logic [CNT_W-1:0]   r_ocount;

    logic [LEN_W-1:0] w_len;
    logic [CMP_W-1:0] w_lhs;
    logic [CMP_W-1:0] w_rhs;
    logic             w_dark;
    logic [IW-1:0]    w_d;
    logic             w_stop1;
    logic             w_stop2;
    logic             w_found;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basic   <= BASIC_RST;
            r_slope   <= SLOPE_RST;
            r_factor  <= FACTOR_RST;
            r_cluster <= CLUSTER_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BASIC:   r_basic   <= i_cfg.data;
                CFG_SLOPE:   r_slope   <= i_cfg.data;
                CFG_FACTOR:  r_factor  <= i_cfg.data;
                CFG_CLUSTER: r_cluster <= i_cfg.data[CLUSTER_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero ray length counts as one
    assign w_len = (r_item.ray_length == '0) ? LEN_W'(1) : r_item.ray_length;

    // luma*L*2^16 < min*L*2^16 + max*(basic*L + slope*i)
    assign w_lhs  = CMP_W'(r_pc) << FRAC_W;
    assign w_rhs  = (CMP_W'(r_pd) << FRAC_W) + CMP_W'(r_pe);
    assign w_dark = (r_item.luma != '0) && (w_lhs < w_rhs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.mul1) begin
            r_pa <= PA_W'(r_basic) * PA_W'(w_len);
            r_pb <= PB_W'(r_slope) * PB_W'(r_idx);
            r_pc <= PC_W'(r_item.luma) * PC_W'(w_len);
            r_pd <= PC_W'(r_item.frame_min_luma) * PC_W'(w_len);
        end
        if (i_cmd.mul2) begin
            r_pe <= E_W'(r_item.frame_max_luma) * E_W'(SUM_W'(r_pa) + SUM_W'(r_pb));
        end
        if (i_cmd.upd) begin
            r_dark <= w_dark;
        end
    end

    // early-stop tests on the updated run state
    assign w_d = r_idx - r_run_start;

    assign w_stop1 = r_dark && (r_run_start != '0)
                   && (RS_W'(r_run_count) * RS_W'(r_run_start) > RS_W'(r_factor))
                   && (DC_W'(w_d) < DC_W'(r_cluster));

    assign w_stop2 = (r_run_start != '0) && (r_run_count != '0) && (r_idx >= r_run_start)
                   && (DS_W'(w_d) * DS_W'(r_run_start) > DS_W'(r_factor))
                   && (CD_W'(r_cluster) * CD_W'(w_d) < CD_W'(r_run_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_idx       <= '0;
            r_run_count <= '0;
            r_run_start <= '0;
            r_collected <= '0;
            r_stopped   <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                if (w_dark) begin
                    if (r_run_count == '0) begin
                        r_run_start <= r_idx;
                        r_collected <= CNT_W'(1);
                    end else if (r_collected != COUNT_LIMIT) begin
                        r_collected <= r_collected + CNT_W'(1);
                    end
                    if (r_run_count != COUNT_LIMIT) begin
                        r_run_count <= r_run_count + CNT_W'(1);
                    end
                end else if (r_run_count != '0) begin
                    r_run_count <= r_run_count - CNT_W'(1);
                end
            end
            if (i_cmd.chk) begin
                if (w_stop1 || w_stop2) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    assign w_found = (r_run_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ofound <= w_found;
            r_ostart <= w_found ? START_W'(r_run_start) : '0;
            r_ocount <= w_found ? r_collected : '0;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.found       = r_ofound;
    assign o_out.start_index = r_ostart;
    assign o_out.point_count = r_ocount;

    assign o_sts.skip     = r_stopped || (r_idx >= IW'(MAX_RAY_SAMPLES));
    assign o_sts.last     = r_item.last_in_ray;
    assign o_sts.out_busy = r_ovalid && !o_out.ready;

`ifndef SYNTH
    a_run_le_collected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= r_collected)
        else $error("run count exceeds collected points");
    a_start_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_start <= r_idx)
        else $error("run start lies beyond the sample index");
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !i_cmd.emit) |=> ($stable(r_idx) && r_stopped))
        else $error("stopped ray advanced its index");
`endif

endmodule

// ===== tb/rdrd_ray_checker.sv =====
`timescale 1ns / 1ps

module rdrd_ray_checker
    import rdrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rdrd_in_if   i_in,
    rdrd_cfg_if  i_cfg,
    rdrd_out_if  i_out,
    output int   o_mismatches,
    output int   o_waiting
);

    localparam int               RAY_CAP = MAX_RAY_SAMPLES_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_index;
        logic [CNT_W-1:0]   point_count;
    } t_ray_result;

    logic [FRAC_W-1:0]    basic_q;
    logic [FRAC_W-1:0]    slope_q;
    logic [FACTOR_W-1:0]  factor_q;
    logic [CLUSTER_W-1:0] cluster_q;

    logic [LEN_W-1:0]   pos_q;
    logic [CNT_W-1:0]   run_q;
    logic [START_W-1:0] first_q;
    logic [CNT_W-1:0]   dark_pts_q;
    logic               halted_q;

    t_ray_result awaited_rays[$];

    task automatic report(input string msg);
        $display("%0t ray checker: %s", $realtime, msg);
        o_mismatches++;
    endtask

    task automatic clear_ray();
        pos_q      = '0;
        run_q      = '0;
        first_q    = '0;
        dark_pts_q = '0;
        halted_q   = 1'b0;
    endtask

    // Exact integer form of luma < min + max * (basic + slope * pos / len) / 65536
    function automatic bit below_threshold(input t_in_item s, input logic [LEN_W-1:0] pos);
        logic [63:0] len;
        logic [63:0] lhs;
        logic [63:0] rhs;
        if (s.luma == '0)
            return 1'b0;
        len = (s.ray_length == '0) ? 64'd1 : 64'(s.ray_length);
        lhs = 64'(s.luma) * 64'd65536 * len;
        rhs = 64'(s.frame_min_luma) * 64'd65536 * len
            + 64'(s.frame_max_luma) * (64'(basic_q) * len + 64'(slope_q) * 64'(pos));
        return lhs < rhs;
    endfunction

    task automatic scan_sample(input t_in_item s);
        logic [63:0] pos;
        logic [63:0] first;
        logic [63:0] gap;
        if (halted_q || pos_q >= RAY_CAP)
            return;
        pos = 64'(pos_q);
        if (below_threshold(s, pos_q)) begin
            if (run_q == '0) begin
                first_q    = pos_q[START_W-1:0];
                dark_pts_q = '0;
            end
            if (dark_pts_q != CNT_MAX)
                dark_pts_q++;
            if (run_q != CNT_MAX)
                run_q++;
            first = 64'(first_q);
            // enough points close together
            if (first != 0 && 64'(run_q) * first > 64'(factor_q)
                    && pos - first < 64'(cluster_q)) begin
                halted_q = 1'b1;
                return;
            end
        end else if (run_q != '0) begin
            run_q--;
        end
        first = 64'(first_q);
        // dense run
        if (first != 0 && run_q != '0 && pos >= first) begin
            gap = pos - first;
            if (gap * first > 64'(factor_q) && 64'(cluster_q) * gap < 64'(run_q)) begin
                halted_q = 1'b1;
                return;
            end
        end
        pos_q++;
    endtask

    always @(posedge i_clk) begin : watch
        t_in_item    s;
        t_ray_result got;
        t_ray_result want;
        if (!i_rst_n) begin
            basic_q   = BASIC_RST;
            slope_q   = SLOPE_RST;
            factor_q  = FACTOR_RST;
            cluster_q = CLUSTER_RST;
            clear_ray();
            awaited_rays.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_BASIC:   basic_q   = i_cfg.data[FRAC_W-1:0];
                    CFG_SLOPE:   slope_q   = i_cfg.data[FRAC_W-1:0];
                    CFG_FACTOR:  factor_q  = i_cfg.data[FACTOR_W-1:0];
                    CFG_CLUSTER: cluster_q = i_cfg.data[CLUSTER_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.found       = i_out.found;
                got.start_index = i_out.start_index;
                got.point_count = i_out.point_count;
                if (awaited_rays.size() == 0) begin
                    report($sformatf("unexpected beat found=%0d start=%0d points=%0d",
                                     got.found, got.start_index, got.point_count));
                end else begin
                    want = awaited_rays.pop_front();
                    if (got.found !== want.found)
                        report($sformatf("found %0b, predicted %0b", got.found, want.found));
                    if (got.start_index !== want.start_index)
                        report($sformatf("start_index %0d, predicted %0d",
                                         got.start_index, want.start_index));
                    if (got.point_count !== want.point_count)
                        report($sformatf("point_count %0d, predicted %0d",
                                         got.point_count, want.point_count));
                end
            end
            if (i_in.valid && i_in.ready) begin
                s.luma           = i_in.luma;
                s.ray_length     = i_in.ray_length;
                s.frame_min_luma = i_in.frame_min_luma;
                s.frame_max_luma = i_in.frame_max_luma;
                s.last_in_ray    = i_in.last_in_ray;
                scan_sample(s);
                if (s.last_in_ray) begin
                    want.found       = (run_q != '0);
                    want.start_index = want.found ? first_q : '0;
                    want.point_count = want.found ? dark_pts_q : '0;
                    awaited_rays = {awaited_rays, want};
                    clear_ray();
                end
            end
        end
        o_waiting = awaited_rays.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rdrd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bit   gaps_on;
    int   items_sent;
    int   mismatches;
    int   waiting;

    rdrd_in_if  in_ch ();
    rdrd_cfg_if cfg_ch ();
    rdrd_out_if out_ch ();

    ray_dark_run_detector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    rdrd_ray_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= !gaps_on || ($urandom_range(99) >= 9);
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Leave valid high when the next beat follows straight on
    task automatic put_sample(input logic [LUMA_W-1:0] luma, input logic [LEN_W-1:0] len,
                              input logic [LUMA_W-1:0] mn, input logic [LUMA_W-1:0] mx,
                              input logic last);
        if (gaps_on && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.luma           <= luma;
        in_ch.ray_length     <= len;
        in_ch.frame_min_luma <= mn;
        in_ch.frame_max_luma <= mx;
        in_ch.last_in_ray    <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Unless noisy: bright lead-in, mostly dark stretch, then bright tail with stray dark pixels
    task automatic run_ray(input int n, input bit noisy);
        logic [LUMA_W-1:0] mn;
        logic [LUMA_W-1:0] mx;
        logic [LUMA_W-1:0] luma;
        int                lead;
        int                dark_len;
        mn       = LUMA_W'($urandom_range(8, 64));
        mx       = LUMA_W'($urandom_range(120, 255));
        lead     = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, n - 1);
        dark_len = $urandom_range(1, n);
        for (int k = 0; k < n; k++) begin
            if (noisy) begin
                put_sample(LUMA_W'($urandom), LEN_W'($urandom), LUMA_W'($urandom),
                           LUMA_W'($urandom), k == n - 1);
            end else begin
                if ($urandom_range(99) < 3)
                    luma = '0;
                else if (k >= lead && k < lead + dark_len && $urandom_range(9) != 0)
                    luma = LUMA_W'($urandom_range(1, mn - 1));
                else if (k >= lead + dark_len && $urandom_range(3) == 0)
                    luma = LUMA_W'($urandom_range(1, mn - 1));
                else
                    luma = LUMA_W'($urandom_range(200, 255));
                put_sample(luma, LEN_W'(n), mn, mx, k == n - 1);
            end
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0)
            @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic random_phase(input int quota);
        int goal;
        goal = items_sent + quota;
        while (items_sent < goal)
            run_ray(($urandom_range(99) < 4) ? $urandom_range(41, 200) : $urandom_range(1, 40),
                    $urandom_range(9) == 0);
        drain();
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] basic, input logic [CFG_DATA_W-1:0] slope,
                             input logic [CFG_DATA_W-1:0] factor,
                             input logic [CFG_DATA_W-1:0] cluster);
        t_cfg_idx              order [4];
        logic [CFG_DATA_W-1:0] vals  [4];
        order = '{CFG_BASIC, CFG_SLOPE, CFG_FACTOR, CFG_CLUSTER};
        vals  = '{basic, slope, factor, cluster};
        for (int r = 0; r < 4; r++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[r];
            cfg_ch.data  <= vals[r];
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int k;
        gaps_on              = 1'b1;
        items_sent           = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.luma          <= '0;
        in_ch.ray_length    <= '0;
        in_ch.frame_min_luma <= '0;
        in_ch.frame_max_luma <= '0;
        in_ch.last_in_ray   <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_BASIC;
        cfg_ch.data         <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-sample rays: invalid luma, zero length, longest length field, top luma
        put_sample(8'd0, 10'd1, 8'd10, 8'd200, 1'b1);
        put_sample(8'd1, 10'd0, 8'd255, 8'd255, 1'b1);
        put_sample(8'd255, 10'd1023, 8'd0, 8'd0, 1'b1);
        put_sample(8'd255, 10'd1, 8'd255, 8'd255, 1'b1);
        // run starting at index zero keeps the early stops off
        for (k = 0; k < 5; k++)
            put_sample(8'd1, 10'd5, 8'd50, 8'd200, k == 4);
        // late run with one bright pixel inside it
        for (k = 0; k < 12; k++)
            put_sample((k < 3 || k == 7) ? 8'd250 : 8'd2, 10'd12, 8'd0, 8'd255, k == 11);
        drain();

        random_phase(70);
        load_regs(16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(70);
        load_regs(16'hffff, 16'hffff, 16'hffff, 16'h00ff);
        random_phase(70);

        // long stretch without any idling on either side
        gaps_on = 1'b0;
        load_regs(16'd3277, 16'd19661, 16'd20, 16'd1);
        random_phase(90);
        gaps_on = 1'b1;

        // ray running past the sample limit, early stops mostly off
        load_regs(16'd3277, 16'd19661, 16'hffff, 16'd0);
        run_ray(520, 1'b0);
        drain();
        load_regs(16'd3277, 16'd19661, 16'd100, 16'd10);
        random_phase(60);

        repeat (4) begin
            load_regs(CFG_DATA_W'($urandom_range(0, 8000)),
                      CFG_DATA_W'($urandom_range(0, 40000)),
                      CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom
                                                           : $urandom_range(0, 400)),
                      CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom
                                                           : $urandom_range(0, 12)));
            random_phase(60);
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
